/* design/nsj_pkg.sv */
package nsj_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ONE       = 1 << FRAC_BITS;

	localparam int GAMMA_W     = 18;
	localparam int GAMMA_RESET = 91750;

	// wide working type for clamps and rescaling
	typedef logic signed [71:0] wide_t;

	localparam wide_t ONE_W     = wide_t'(ONE);
	localparam wide_t FRAC_MASK = ONE_W - wide_t'(1);
	localparam wide_t LIM_A2    = (wide_t'(1) <<< (62 - FRAC_BITS)) - wide_t'(1);
	localparam wide_t LIM_MR    = (wide_t'(1) <<< 31) - wide_t'(1);
	localparam wide_t LIM_M2    = (wide_t'(1) <<< 37) - wide_t'(1);
	localparam wide_t LIM_R     = wide_t'(1) <<< 32;
	localparam wide_t LIM_T2    = wide_t'(1) <<< 38;
	localparam wide_t LIM_Q     = wide_t'(1) <<< 31;
	localparam wide_t MAX32     = (wide_t'(1) <<< 31) - wide_t'(1);
	localparam wide_t MIN32     = -(wide_t'(1) <<< 31);

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_INPUT    = 2'd1,
		ST_ZERO_DENSITY = 2'd2,
		ST_SATURATED    = 2'd3
	} status_t;

	// restoring divider slice: one quotient bit per stage
	localparam int DIV_NW = 56;
	localparam int DIV_DW = 42;
	localparam int DIV_IW = 6;

	typedef struct packed {
		logic [DIV_NW-1:0] num;
		logic [DIV_NW-1:0] quo;
		logic [DIV_DW:0]   rem;
		logic [DIV_DW-1:0] den;
	} div_t;

	typedef struct packed {
		logic [63:0] v;
		logic [63:0] res;
	} sqrt_t;

	typedef struct packed {
		wide_t v;
		logic  sat;
	} clip_t;

	// everything an item carries down the pipeline
	typedef struct packed {
		logic               bad;
		logic               zden;
		logic               sat;
		logic               den_neg;
		logic               t2_neg;
		status_t            status;
		logic signed [31:0] rho;
		logic signed [31:0] u;
		logic signed [31:0] p;
		logic signed [31:0] ms;
		logic [30:0]        a;
		logic [31:0]        ud;
		logic [36:0]        m2;
		logic signed [39:0] t2;
		logic signed [33:0] ratio;
		logic signed [33:0] s;
		logic signed [31:0] ql;
		logic signed [31:0] pl;
		logic signed [31:0] ul;
		logic signed [32:0] q;
		logic signed [32:0] c;
		logic signed [32:0] w;
		logic signed [47:0] uq;
		wide_t              pa;
		wide_t              pb;
		wide_t              pc;
		div_t               dv0;
		div_t               dv1;
		sqrt_t              sq;
	} ctx_t;

	// pipeline map
	localparam int N_A2  = 49;
	localparam int N_SQ  = 32;
	localparam int N_MR  = 48;
	localparam int N_RS  = 56;
	localparam int N_Q   = 47;

	localparam int STG_IN  = 0;
	localparam int STG_A2D = STG_IN + 1;
	localparam int STG_A2C = STG_A2D + N_A2;
	localparam int STG_SQ  = STG_A2C + 1;
	localparam int STG_MRI = STG_SQ + N_SQ;
	localparam int STG_MRD = STG_MRI + 1;
	localparam int STG_D   = STG_MRD + N_MR;
	localparam int STG_SQM = STG_D + 1;
	localparam int STG_M2  = STG_SQM + 1;
	localparam int STG_GM  = STG_M2 + 1;
	localparam int STG_DEN = STG_GM + 1;
	localparam int STG_RSD = STG_DEN + 1;
	localparam int STG_RS  = STG_RSD + N_RS;
	localparam int STG_PM  = STG_RS + 1;
	localparam int STG_QL  = STG_PM + 1;
	localparam int STG_QD  = STG_QL + 1;
	localparam int STG_Q   = STG_QD + N_Q;
	localparam int STG_CM  = STG_Q + 1;
	localparam int STG_W   = STG_CM + 1;
	localparam int STG_WA  = STG_W + 1;
	localparam int STG_OUT = STG_WA + 1;
	localparam int NUM_STAGES = STG_OUT + 1;

	// divide by 2^FRAC_BITS, rounding toward zero
	function automatic wide_t trunc_frac(input wide_t x);
		wide_t t;
		t = (x < 0) ? (x + FRAC_MASK) : x;
		return t >>> FRAC_BITS;
	endfunction

	function automatic clip_t clip(input wide_t x, input wide_t lo, input wide_t hi);
		clip_t r;
		r.sat = 1'b0;
		r.v   = x;
		if (x < lo) begin
			r.v   = lo;
			r.sat = 1'b1;
		end else if (x > hi) begin
			r.v   = hi;
			r.sat = 1'b1;
		end
		return r;
	endfunction

	function automatic div_t div_step(input div_t d, input logic [DIV_IW-1:0] idx);
		div_t          r;
		logic [DIV_DW:0]   rn;
		logic [DIV_DW+1:0] diff;
		r    = d;
		rn   = {d.rem[DIV_DW-1:0], d.num[idx]};
		diff = {1'b0, rn} - {2'b00, d.den};
		if (!diff[DIV_DW+1]) begin
			r.rem = diff[DIV_DW:0];
			r.quo = {d.quo[DIV_NW-2:0], 1'b1};
		end else begin
			r.rem = rn;
			r.quo = {d.quo[DIV_NW-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [4:0] k);
		sqrt_t       r;
		logic [63:0] bitv;
		logic [63:0] sum;
		r    = s;
		bitv = 64'd1 << {k, 1'b0};
		sum  = s.res + bitv;
		if (s.v >= sum) begin
			r.v   = s.v - sum;
			r.res = (s.res >> 1) + bitv;
		end else begin
			r.res = s.res >> 1;
		end
		return r;
	endfunction

endpackage

/* design/nsj_if.sv */
interface nsj_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] upstream_density;
	logic signed [31:0] upstream_velocity;
	logic signed [31:0] upstream_pressure;
	logic signed [31:0] shock_mach;

	modport source (output valid, output upstream_density, output upstream_velocity,
		output upstream_pressure, output shock_mach, input ready);
	modport sink (input valid, input upstream_density, input upstream_velocity,
		input upstream_pressure, input shock_mach, output ready);
endinterface

interface nsj_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] shocked_density;
	logic signed [31:0] shocked_velocity;
	logic signed [31:0] shocked_pressure;
	logic [1:0]         status;

	modport source (output valid, output shocked_density, output shocked_velocity,
		output shocked_pressure, output status, input ready);
	modport sink (input valid, input shocked_density, input shocked_velocity,
		input shocked_pressure, input status, output ready);
endinterface

/* design/normal_shock_jump_state_unit.sv */
// Normal shock jump: takes one upstream gas state (density, velocity, pressure, all signed
// Q16.16) and a shock Mach number per word and returns the state across the shock by the
// Rankine-Hugoniot relations, with a status code (ok, bad input, zero shocked density,
// saturated). Gamma must be written through cfg_we/cfg_wdata only while no word is in
// flight; the block does not enforce this. Gamma resets to 1.4. The datapath is a
// 248-stage pipeline: a new word enters every clock while the output side does not
// stall. The depth is set by five one-bit-per-stage restoring dividers (49, 48, 56, 47
// stages; the pressure-ratio division runs beside the density-ratio one) and a 32-stage
// square root for the sound speed. The whole pipeline holds as one while the output word
// waits, so upstream ready drops only when the last stage is full and not being taken.
module normal_shock_jump_state_unit
	import nsj_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [GAMMA_W-1:0]  cfg_wdata,
	nsj_in_if.sink              upstream,
	nsj_out_if.source           shocked
);

	logic [GAMMA_W-1:0]    gamma_q;
	logic [18:0]           gp1;
	logic signed [18:0]    gm1;
	logic                  adv;
	logic [NUM_STAGES-1:0] vld_s;
	ctx_t                  pipe_s [NUM_STAGES];
	ctx_t                  nxt    [NUM_STAGES];

	// gamma register; the user must hold it stable while words are in flight, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= GAMMA_W'(GAMMA_RESET);
		end else if (cfg_we) begin
			gamma_q <= cfg_wdata;
		end
	end

	assign gp1 = {1'b0, gamma_q} + 19'(ONE);
	assign gm1 = $signed({1'b0, gamma_q} - 19'(ONE));

	// advance everything unless the output word is held
	assign adv            = !vld_s[STG_OUT] || shocked.ready;
	assign upstream.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NUM_STAGES-2:0], upstream.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				pipe_s[i] <= nxt[i];
			end
		end
	end

	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
		if (i == STG_IN) begin : g_in
			// capture the word, flag bad input, start gamma*p / rho
			always_comb begin
				logic [48:0] gpr;
				nxt[i]     = ctx_t'('0);
				nxt[i].rho = upstream.upstream_density;
				nxt[i].u   = upstream.upstream_velocity;
				nxt[i].p   = upstream.upstream_pressure;
				nxt[i].ms  = upstream.shock_mach;
				nxt[i].bad = (upstream.upstream_density <= 0) ||
					(upstream.upstream_pressure <= 0);
				gpr            = gamma_q * upstream.upstream_pressure[30:0];
				nxt[i].dv0.num = DIV_NW'(gpr);
				nxt[i].dv0.den = DIV_DW'(upstream.upstream_density[30:0]);
			end
		end else if (i >= STG_A2D && i < STG_A2C) begin : g_a2d
			localparam int BitIdx = N_A2 - 1 - (i - STG_A2D);
			always_comb begin
				nxt[i]     = pipe_s[i-1];
				nxt[i].dv0 = div_step(pipe_s[i-1].dv0, DIV_IW'(BitIdx));
			end
		end else if (i == STG_A2C) begin : g_a2c
			// clamp a^2, scale it for the root
			always_comb begin
				clip_t cl;
				nxt[i]        = pipe_s[i-1];
				cl            = clip(wide_t'(pipe_s[i-1].dv0.quo[N_A2-1:0]), '0, LIM_A2);
				nxt[i].sat    = pipe_s[i-1].sat | cl.sat;
				nxt[i].sq.v   = 64'(cl.v) << FRAC_BITS;
				nxt[i].sq.res = '0;
			end
		end else if (i >= STG_SQ && i < STG_MRI) begin : g_sq
			localparam int Pair = N_SQ - 1 - (i - STG_SQ);
			always_comb begin
				nxt[i]    = pipe_s[i-1];
				nxt[i].sq = sqrt_step(pipe_s[i-1].sq, 5'(Pair));
			end
		end else if (i == STG_MRI) begin : g_mri
			// raise a zero sound speed to one LSB, start |u|/a
			always_comb begin
				logic [31:0] uabs;
				nxt[i]   = pipe_s[i-1];
				nxt[i].a = (pipe_s[i-1].sq.res == '0) ? 31'd1 : pipe_s[i-1].sq.res[30:0];
				uabs     = pipe_s[i-1].u[31] ? 32'(-pipe_s[i-1].u) : 32'(pipe_s[i-1].u);
				nxt[i].dv0.num = DIV_NW'(uabs) << FRAC_BITS;
				nxt[i].dv0.den = DIV_DW'(nxt[i].a);
				nxt[i].dv0.rem = '0;
				nxt[i].dv0.quo = '0;
			end
		end else if (i >= STG_MRD && i < STG_D) begin : g_mrd
			localparam int BitIdx = N_MR - 1 - (i - STG_MRD);
			always_comb begin
				nxt[i]     = pipe_s[i-1];
				nxt[i].dv0 = div_step(pipe_s[i-1].dv0, DIV_IW'(BitIdx));
			end
		end else if (i == STG_D) begin : g_d
			// relative Mach number and its magnitude
			always_comb begin
				wide_t mq;
				wide_t d;
				clip_t cl;
				nxt[i]     = pipe_s[i-1];
				mq         = wide_t'(pipe_s[i-1].dv0.quo[N_MR-1:0]);
				cl         = clip(pipe_s[i-1].u[31] ? -mq : mq, -LIM_MR, LIM_MR);
				nxt[i].sat = pipe_s[i-1].sat | cl.sat;
				d          = cl.v - wide_t'(pipe_s[i-1].ms);
				nxt[i].ud  = (d < 0) ? 32'(-d) : 32'(d);
			end
		end else if (i == STG_SQM) begin : g_sqm
			// square the magnitude as 16-bit halves
			always_comb begin
				logic [31:0] hh;
				logic [31:0] hl;
				logic [31:0] ll;
				nxt[i]    = pipe_s[i-1];
				hh        = pipe_s[i-1].ud[31:16] * pipe_s[i-1].ud[31:16];
				hl        = pipe_s[i-1].ud[31:16] * pipe_s[i-1].ud[15:0];
				ll        = pipe_s[i-1].ud[15:0] * pipe_s[i-1].ud[15:0];
				nxt[i].pa = wide_t'(hh);
				nxt[i].pb = wide_t'(hl);
				nxt[i].pc = wide_t'(ll);
			end
		end else if (i == STG_M2) begin : g_m2
			always_comb begin
				logic [63:0] sq64;
				clip_t       cl;
				nxt[i]     = pipe_s[i-1];
				sq64       = ({32'd0, pipe_s[i-1].pa[31:0]} << 32) +
					({32'd0, pipe_s[i-1].pb[31:0]} << 17) + {32'd0, pipe_s[i-1].pc[31:0]};
				cl         = clip(wide_t'(sq64 >> FRAC_BITS), '0, LIM_M2);
				nxt[i].sat = pipe_s[i-1].sat | cl.sat;
				nxt[i].m2  = cl.v[36:0];
			end
		end else if (i == STG_GM) begin : g_gm
			// (gamma-1)*m2, (gamma+1)*m2, gamma*m2
			always_comb begin
				logic signed [56:0] pgm;
				logic [55:0]        pgp;
				logic [54:0]        pgc;
				nxt[i]    = pipe_s[i-1];
				pgm       = gm1 * $signed({1'b0, pipe_s[i-1].m2});
				pgp       = gp1 * pipe_s[i-1].m2;
				pgc       = gamma_q * pipe_s[i-1].m2;
				nxt[i].pa = wide_t'(pgm);
				nxt[i].pb = wide_t'(pgp);
				nxt[i].pc = wide_t'(pgc);
			end
		end else if (i == STG_DEN) begin : g_den
			// density-ratio denominator; pressure term; start both divisions
			always_comb begin
				wide_t den;
				wide_t dabs;
				wide_t tabs;
				clip_t cl;
				nxt[i]         = pipe_s[i-1];
				den            = trunc_frac(pipe_s[i-1].pa) + (ONE_W <<< 1);
				nxt[i].zden    = pipe_s[i-1].zden | (den == '0);
				nxt[i].den_neg = den < 0;
				dabs           = (den < 0) ? -den : den;
				cl             = clip(((pipe_s[i-1].pc <<< 1) >>> FRAC_BITS) - wide_t'(gm1),
					-LIM_T2, LIM_T2);
				nxt[i].sat     = pipe_s[i-1].sat | cl.sat;
				nxt[i].t2      = cl.v[39:0];
				nxt[i].t2_neg  = cl.v < 0;
				tabs           = (cl.v < 0) ? -cl.v : cl.v;
				nxt[i].dv0.num = pipe_s[i-1].pb[DIV_NW-1:0];
				nxt[i].dv0.den = dabs[DIV_DW-1:0];
				nxt[i].dv0.rem = '0;
				nxt[i].dv0.quo = '0;
				nxt[i].dv1.num = DIV_NW'(tabs) << FRAC_BITS;
				nxt[i].dv1.den = DIV_DW'(gp1);
				nxt[i].dv1.rem = '0;
				nxt[i].dv1.quo = '0;
			end
		end else if (i >= STG_RSD && i < STG_RS) begin : g_rsd
			localparam int BitIdx = N_RS - 1 - (i - STG_RSD);
			always_comb begin
				nxt[i]     = pipe_s[i-1];
				nxt[i].dv0 = div_step(pipe_s[i-1].dv0, DIV_IW'(BitIdx));
				nxt[i].dv1 = div_step(pipe_s[i-1].dv1, DIV_IW'(BitIdx));
			end
		end else if (i == STG_RS) begin : g_rs
			always_comb begin
				wide_t q0;
				wide_t q1;
				clip_t c0;
				clip_t c1;
				nxt[i]       = pipe_s[i-1];
				q0           = wide_t'(pipe_s[i-1].dv0.quo);
				q1           = wide_t'(pipe_s[i-1].dv1.quo);
				c0           = clip(pipe_s[i-1].den_neg ? -q0 : q0, -LIM_R, LIM_R);
				c1           = clip(pipe_s[i-1].t2_neg ? -q1 : q1, -LIM_R, LIM_R);
				nxt[i].sat   = pipe_s[i-1].sat | c0.sat | c1.sat;
				nxt[i].ratio = c0.v[33:0];
				nxt[i].s     = c1.v[33:0];
			end
		end else if (i == STG_PM) begin : g_pm
			always_comb begin
				logic signed [65:0] pr;
				logic signed [65:0] ps;
				nxt[i]    = pipe_s[i-1];
				pr        = pipe_s[i-1].rho * pipe_s[i-1].ratio;
				ps        = pipe_s[i-1].p * pipe_s[i-1].s;
				nxt[i].pa = wide_t'(pr);
				nxt[i].pb = wide_t'(ps);
			end
		end else if (i == STG_QL) begin : g_ql
			// shocked density and pressure; start rho / rho'
			always_comb begin
				clip_t       cd;
				clip_t       cp;
				logic [31:0] qabs;
				nxt[i]      = pipe_s[i-1];
				cd          = clip(trunc_frac(pipe_s[i-1].pa), MIN32, MAX32);
				cp          = clip(trunc_frac(pipe_s[i-1].pb), MIN32, MAX32);
				nxt[i].sat  = pipe_s[i-1].sat | cd.sat | cp.sat;
				nxt[i].ql   = cd.v[31:0];
				nxt[i].pl   = cp.v[31:0];
				nxt[i].zden = pipe_s[i-1].zden | (cd.v == '0);
				qabs        = cd.v[31] ? 32'(-cd.v) : 32'(cd.v);
				nxt[i].dv0.num = DIV_NW'(pipe_s[i-1].rho[30:0]) << FRAC_BITS;
				nxt[i].dv0.den = DIV_DW'(qabs);
				nxt[i].dv0.rem = '0;
				nxt[i].dv0.quo = '0;
			end
		end else if (i >= STG_QD && i < STG_Q) begin : g_qd
			localparam int BitIdx = N_Q - 1 - (i - STG_QD);
			always_comb begin
				nxt[i]     = pipe_s[i-1];
				nxt[i].dv0 = div_step(pipe_s[i-1].dv0, DIV_IW'(BitIdx));
			end
		end else if (i == STG_Q) begin : g_q
			always_comb begin
				wide_t qm;
				clip_t cq;
				clip_t cc;
				nxt[i]     = pipe_s[i-1];
				qm         = wide_t'(pipe_s[i-1].dv0.quo[N_Q-1:0]);
				cq         = clip(pipe_s[i-1].ql[31] ? -qm : qm, -LIM_Q, LIM_Q);
				cc         = clip(ONE_W - cq.v, -LIM_Q, LIM_Q);
				nxt[i].sat = pipe_s[i-1].sat | cq.sat | cc.sat;
				nxt[i].q   = cq.v[32:0];
				nxt[i].c   = cc.v[32:0];
			end
		end else if (i == STG_CM) begin : g_cm
			always_comb begin
				logic signed [64:0] pcm;
				logic signed [64:0] puq;
				nxt[i]    = pipe_s[i-1];
				pcm       = pipe_s[i-1].c * pipe_s[i-1].ms;
				puq       = pipe_s[i-1].u * pipe_s[i-1].q;
				nxt[i].pa = wide_t'(pcm);
				nxt[i].pb = wide_t'(puq);
			end
		end else if (i == STG_W) begin : g_w
			always_comb begin
				clip_t cw;
				wide_t tq;
				nxt[i]     = pipe_s[i-1];
				cw         = clip(trunc_frac(pipe_s[i-1].pa), -LIM_Q, LIM_Q);
				nxt[i].sat = pipe_s[i-1].sat | cw.sat;
				nxt[i].w   = cw.v[32:0];
				tq         = trunc_frac(pipe_s[i-1].pb);
				nxt[i].uq  = tq[47:0];
			end
		end else if (i == STG_WA) begin : g_wa
			always_comb begin
				logic signed [64:0] pwa;
				nxt[i]    = pipe_s[i-1];
				pwa       = pipe_s[i-1].w * $signed({1'b0, pipe_s[i-1].a});
				nxt[i].pa = wide_t'(pwa);
			end
		end else begin : g_out
			// shocked velocity, status, zero the values on a failed word
			always_comb begin
				clip_t cu;
				nxt[i] = pipe_s[i-1];
				cu     = clip(trunc_frac(pipe_s[i-1].pa) + wide_t'(pipe_s[i-1].uq),
					MIN32, MAX32);
				nxt[i].ul = cu.v[31:0];
				if (pipe_s[i-1].bad) begin
					nxt[i].status = ST_BAD_INPUT;
				end else if (pipe_s[i-1].zden) begin
					nxt[i].status = ST_ZERO_DENSITY;
				end else if (pipe_s[i-1].sat || cu.sat) begin
					nxt[i].status = ST_SATURATED;
				end else begin
					nxt[i].status = ST_OK;
				end
				if (pipe_s[i-1].bad || pipe_s[i-1].zden) begin
					nxt[i].ql = '0;
					nxt[i].pl = '0;
					nxt[i].ul = '0;
				end
			end
		end
	end

	assign shocked.valid            = vld_s[STG_OUT];
	assign shocked.shocked_density  = pipe_s[STG_OUT].ql;
	assign shocked.shocked_velocity = pipe_s[STG_OUT].ul;
	assign shocked.shocked_pressure = pipe_s[STG_OUT].pl;
	assign shocked.status           = pipe_s[STG_OUT].status;

	// failed words carry zero values
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		shocked.valid && (shocked.status == ST_BAD_INPUT ||
			shocked.status == ST_ZERO_DENSITY) |->
		shocked.shocked_density == 0 && shocked.shocked_velocity == 0 &&
		shocked.shocked_pressure == 0)
		else $error("failed word with nonzero values");

	// a good word never reports zero density
	a_ok_density: assert property (@(posedge clk) disable iff (!arst_n)
		shocked.valid && (shocked.status == ST_OK || shocked.status == ST_SATURATED) |->
		shocked.shocked_density != 0)
		else $error("zero density with good status");

	// a stall freezes the valid chain
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved during stall");

	// sound speed feeding the velocity divider is never zero
	a_speed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[STG_MRI] |-> pipe_s[STG_MRI].a != '0)
		else $error("zero sound speed");

endmodule

/* tb/nsj_tb_if.sv */
`timescale 1ns / 100ps

interface nsj_cfg_if;
	logic                       we;
	logic [nsj_pkg::GAMMA_W-1:0] wdata;
endinterface

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Scoreboard for the shock jump unit: keeps the current gamma, predicts the
// post-shock word for each accepted upstream word and checks words in order.
class shock_scoreboard;
	typedef struct {
		logic signed [31:0] rho;
		logic signed [31:0] u;
		logic signed [31:0] p;
		logic [1:0]         st;
	} jump_t;

	jump_t       pending[$];
	logic [17:0] gamma;
	int          errors;

	function new();
		gamma  = 18'(nsj_pkg::GAMMA_RESET);
		errors = 0;
	endfunction

	static function longint lim(longint x, longint lo, longint hi, ref bit sat);
		if (x < lo) begin
			sat = 1;
			return lo;
		end
		if (x > hi) begin
			sat = 1;
			return hi;
		end
		return x;
	endfunction

	static function longint floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// Work out the Rankine-Hugoniot jump for one upstream word.
	function jump_t shock_jump(logic signed [31:0] rho_i, u_i, p_i, ms_i);
		longint one, rho, u, p, ms, g, a2, a, mr, d, m2, gp1, gm1, den;
		longint ratio, ql, t2, s, pl, q, c, w, ul;
		longint unsigned ud;
		bit     sat;
		jump_t  r;
		one = 64'sd1 << 16;
		rho = rho_i; u = u_i; p = p_i; ms = ms_i; g = gamma;
		sat = 0;
		r = '{0, 0, 0, nsj_pkg::ST_OK};
		if (rho <= 0 || p <= 0) begin
			r.st = nsj_pkg::ST_BAD_INPUT;
			return r;
		end
		a2 = lim((g * p) / rho, 0, (64'sd1 << 46) - 1, sat);
		a  = floor_sqrt(a2 * one);
		if (a == 0) a = 1;
		mr = lim((u * one) / a, -64'sh7FFFFFFF, 64'sh7FFFFFFF, sat);
		d  = mr - ms;
		ud = d < 0 ? -d : d;
		m2 = lim((ud * ud) >> 16, 0, (64'sd1 << 37) - 1, sat);
		gp1 = g + one;
		gm1 = g - one;
		den = (gm1 * m2) / one + 2 * one;
		if (den == 0) begin
			r.st = nsj_pkg::ST_ZERO_DENSITY;
			return r;
		end
		ratio = lim((gp1 * m2) / den, -(64'sd1 << 32), 64'sd1 << 32, sat);
		ql = lim((rho * ratio) / one, -64'sh80000000, 64'sh7FFFFFFF, sat);
		if (ql == 0) begin
			r.st = nsj_pkg::ST_ZERO_DENSITY;
			return r;
		end
		t2 = lim((2 * g * m2) / one - gm1, -(64'sd1 << 38), 64'sd1 << 38, sat);
		s  = lim((t2 * one) / gp1, -(64'sd1 << 32), 64'sd1 << 32, sat);
		pl = lim((p * s) / one, -64'sh80000000, 64'sh7FFFFFFF, sat);
		q  = lim((rho * one) / ql, -(64'sd1 << 31), 64'sd1 << 31, sat);
		c  = lim(one - q, -(64'sd1 << 31), 64'sd1 << 31, sat);
		w  = lim((c * ms) / one, -(64'sd1 << 31), 64'sd1 << 31, sat);
		ul = lim((w * a) / one + (u * q) / one, -64'sh80000000, 64'sh7FFFFFFF, sat);
		r.rho = 32'(ql);
		r.u   = 32'(ul);
		r.p   = 32'(pl);
		r.st  = sat ? nsj_pkg::ST_SATURATED : nsj_pkg::ST_OK;
		return r;
	endfunction

	function void note_upstream(logic signed [31:0] rho, u, p, ms);
		pending.push_back(shock_jump(rho, u, p, ms));
	endfunction

	function void check_shocked(logic signed [31:0] rho, u, p, logic [1:0] st);
		jump_t e;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected word: %0d %0d %0d st %0d", rho, u, p, st);
			return;
		end
		e = pending.pop_front();
		if (e.rho !== rho || e.u !== u || e.p !== p || e.st !== st) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: exp %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
					e.rho, e.u, e.p, e.st, rho, u, p, st);
		end
	endfunction
endclass

module tb_top;
	import nsj_pkg::*;

	// pipeline depth stated at the head of the block
	localparam int PIPE_DEPTH = 248;

	logic clk = 0;
	logic arst_n = 0;

	nsj_in_if  upstream();
	nsj_out_if shocked();
	nsj_cfg_if cfg();

	shock_scoreboard board = new();

	// idle control for both sides; quiet turns idling off at the end
	bit quiet = 0;
	bit hold_off = 0;

	always #5 clk = ~clk;

	normal_shock_jump_state_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.we),
		.cfg_wdata(cfg.wdata),
		.upstream (upstream.sink),
		.shocked  (shocked.source)
	);

	initial begin
		upstream.valid = 0;
		upstream.upstream_density = 0;
		upstream.upstream_velocity = 0;
		upstream.upstream_pressure = 0;
		upstream.shock_mach = 0;
		shocked.ready = 0;
		cfg.we = 0;
		cfg.wdata = 0;
	end

	// Offer one word and hold it until taken; sometimes idle first.
	task automatic send_word(logic signed [31:0] rho, u, p, ms);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			upstream.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		upstream.valid <= 1;
		upstream.upstream_density <= rho;
		upstream.upstream_velocity <= u;
		upstream.upstream_pressure <= p;
		upstream.shock_mach <= ms;
		do @(posedge clk); while (!upstream.ready);
		board.note_upstream(rho, u, p, ms);
	endtask

	task automatic finish_sending();
		upstream.valid <= 0;
		@(posedge clk);
	endtask

	// Write gamma only with the pipe drained.
	task automatic write_gamma(logic [GAMMA_W-1:0] g);
		finish_sending();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		cfg.we <= 1;
		cfg.wdata <= g;
		@(posedge clk);
		cfg.we <= 0;
		board.gamma = g;
	endtask

	// Random Q16.16 value: half the time moderate, otherwise any 32 bits or any positive value.
	function automatic logic signed [31:0] pick(bit positive);
		logic signed [31:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = $urandom_range(1, 32'h0040_0000);
			2: v = $urandom_range(32'h0000_4000, 32'h0004_0000);
			default: v = $urandom_range(1, 32'h7FFF_FFFF);
		endcase
		if (positive && $urandom_range(0, 15) != 0) begin
			if (v <= 0) v = (v == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v;
			if (v == 0) v = 1;
		end else if (!positive && $urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	task automatic random_burst(int n);
		for (int i = 0; i < n; i++)
			send_word(pick(1), pick(0), pick(1), pick(0));
	endtask

	// Receiver: random stalls, plus a long hold-off on request.
	always @(posedge clk) begin
		if (shocked.valid && shocked.ready)
			board.check_shocked(shocked.shocked_density, shocked.shocked_velocity,
				shocked.shocked_pressure, shocked.status);
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				shocked.ready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 18);
				shocked.ready <= 0;
				repeat (n) @(posedge clk);
			end else begin
				shocked.ready <= 1;
				@(posedge clk);
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: bad input, typical shock, extremes, zero sound speed.
		send_word(0, 0, 32'sh10000, 32'sh20000);
		send_word(32'sh10000, 0, 0, 32'sh20000);
		send_word(-1, 5, 32'sh10000, 0);
		send_word(32'sh10000, 0, 32'sh8000_0000, 0);
		send_word(32'sh10000, 0, 32'sh10000, 32'sh20000);
		send_word(32'sh10000, 32'sh10000, 32'sh10000, 32'sh18000);
		send_word(32'sh10000, 0, 32'sh10000, 0);
		send_word(32'sh10000, 0, 32'sh10000, 32'sh10000);
		send_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_word(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_word(1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_word(32'sh7FFF_FFFF, 1, 1, 32'sh7FFF_FFFF);
		send_word(1, 0, 1, 0);
		send_word(1, 32'sh7FFF_FFFF, 1, 0);
		send_word(32'sh10000, -32'sh10000, 32'sh10000, -32'sh30000);
		send_word(32'sh0001_0000, 32'sh0100_0000, 32'sh0000_0100, 32'sh10000);

		// Long stall on the output: sender keeps offering so the pipe fills.
		hold_off = 1;
		random_burst(350);

		// Sweep gamma: just above one, three, an 18-bit value with gamma-1 negative, the 18-bit max, zero, reset value.
		write_gamma(18'd65537);
		send_word(32'sh10000, 0, 32'sh10000, 32'sh20000);
		send_word(32'sh10000, 32'sh12345, 32'sh10000, 0);
		random_burst(20);
		write_gamma(18'd196608);
		send_word(32'sh10000, 0, 32'sh10000, 32'sh20000);
		random_burst(20);
		write_gamma(18'd30000);
		send_word(32'sh10000, 0, 32'sh10000, 32'sh30000);
		random_burst(20);
		write_gamma(18'h3FFFF);
		random_burst(10);
		write_gamma(18'd0);
		random_burst(10);
		write_gamma(GAMMA_W'(GAMMA_RESET));

		// Final part with no idling on either side.
		quiet = 1;
		random_burst(30);
		finish_sending();

		while (board.pending.size() != 0) @(posedge clk);
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end
endmodule
